>>> sv/kcd_pkg.sv
// Shared types and constants for the keypad scan click/hold detector.
package kcd_pkg;

    localparam int SCAN_COLS = 4;   // key columns carried by one scan
    localparam int SCAN_ROWS = 4;   // rows the 2-bit row index can name
    localparam int ROW_W     = 2;
    localparam int STATE_W   = 8;
    localparam int HOLD_W    = 7;

    // APB register map
    localparam int ADDR_W    = 3;
    localparam int DATA_W    = 32;
    localparam int REG_IDX_W = ADDR_W - 2;
    localparam logic [REG_IDX_W-1:0] REG_HOLD_COUNT = '0;

    localparam logic [HOLD_W-1:0] HOLD_RESET = 7'd80;

    typedef logic signed [STATE_W-1:0] t_state;

    localparam t_state STATE_FREE  = 8'sd0;
    localparam t_state STATE_CLICK = -8'sd1;

    // per-lane result
    typedef struct packed {
        t_state state;
        logic   click;
        logic   hold;
    } t_lane_res;

    // one merged result item
    typedef struct packed {
        logic [ROW_W-1:0]     row;
        t_state [SCAN_COLS-1:0] states;
        logic [SCAN_COLS-1:0] click_mask;
        logic [SCAN_COLS-1:0] hold_mask;
    } t_result;

endpackage

>>> sv/keypad_scan_click_hold_detect_top.sv
// Top level of the keypad scan click/hold detector.
// Accepted results go to the result register, or to the skid slot while one is stalled.
// Throughput: one scan request per cycle while o_ready is high; the key-state read, four
//   lane updates and write-back of the scanned row all complete in the accept cycle.
// Reset (i_rst_n low, synchronous): all key states free, hold_count back to 80,
//   output buffer emptied.
module keypad_scan_click_hold_detect_top #(
    parameter int ROWS = 4,
    parameter int COLS = 4
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,

    // scan request channel
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [1:0]                    i_row,
    input  logic [3:0]                    i_col_levels,

    // result channel
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [1:0]                    o_row_out,
    output logic signed [7:0]             o_key0_state,
    output logic signed [7:0]             o_key1_state,
    output logic signed [7:0]             o_key2_state,
    output logic signed [7:0]             o_key3_state,
    output logic [3:0]                    o_click_mask,
    output logic [3:0]                    o_hold_mask,

    // APB configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [kcd_pkg::ADDR_W-1:0]    paddr,
    input  logic [kcd_pkg::DATA_W-1:0]    pwdata,
    output logic [kcd_pkg::DATA_W-1:0]    prdata,
    output logic                          pready
);

    // Only rows/columns reachable by the scan fields are stored; keys past
    // ROWS or COLS never get state.
    localparam int ROWS_U = (ROWS < kcd_pkg::SCAN_ROWS) ? ROWS : kcd_pkg::SCAN_ROWS;
    localparam int COLS_U = (COLS < kcd_pkg::SCAN_COLS) ? COLS : kcd_pkg::SCAN_COLS;
    localparam int RIDX_W = (ROWS_U > 1) ? $clog2(ROWS_U) : 1;

    // ------------------------------------------------------------------
    // Configuration register
    // ------------------------------------------------------------------
    logic [kcd_pkg::HOLD_W-1:0]    r_hold_count;
    logic                          reg_sel;

    assign reg_sel = (paddr[kcd_pkg::ADDR_W-1:2] == kcd_pkg::REG_HOLD_COUNT);
    assign pready  = 1'b1;
    assign prdata  = reg_sel ? {{(kcd_pkg::DATA_W-kcd_pkg::HOLD_W){1'b0}}, r_hold_count}
                             : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_count <= kcd_pkg::HOLD_RESET;
        end else if (psel && penable && pwrite && pready && reg_sel) begin
            r_hold_count <= pwdata[kcd_pkg::HOLD_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Key state store: each live lane keeps one state per row.
    // Read and written at the requested row in the accept cycle.
    // ------------------------------------------------------------------
    logic               accept;
    logic               row_hit;
    logic [RIDX_W-1:0]  ridx;
    logic               out_room;

    assign o_ready = out_room;
    assign accept  = i_valid && out_room;
    assign row_hit = ({1'b0, i_row} < 3'(ROWS_U));
    assign ridx    = RIDX_W'(i_row);

    // ------------------------------------------------------------------
    // Lanes: one next-state unit per column of the scanned row
    // ------------------------------------------------------------------
    kcd_pkg::t_lane_res lane_res [kcd_pkg::SCAN_COLS];

    for (genvar c = 0; c < kcd_pkg::SCAN_COLS; c++) begin : g_lane
        if (c < COLS_U) begin : g_live
            kcd_pkg::t_state    r_col [ROWS_U];
            kcd_pkg::t_lane_res res;
            kcd_pkg::t_state    cur;

            // out-of-range rows read as free and are masked below
            assign cur = row_hit ? r_col[ridx] : kcd_pkg::STATE_FREE;

            kcd_lane u_lane (
                .i_state      (cur),
                .i_pressed    (!i_col_levels[c]),
                .i_hold_count (r_hold_count),
                .o_res        (res)
            );

            assign lane_res[c] = row_hit ? res : '0;

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    for (int r = 0; r < ROWS_U; r++) begin
                        r_col[r] <= kcd_pkg::STATE_FREE;
                    end
                end else if (accept && row_hit) begin
                    r_col[ridx] <= res.state;
                end
            end
        end else begin : g_dead
            // column not populated: report free, no flags
            assign lane_res[c] = '0;
        end
    end

    // ------------------------------------------------------------------
    // Merge: gather lane states and flags into one result
    // ------------------------------------------------------------------
    kcd_pkg::t_result merged;
    kcd_pkg::t_result out_data;

    always_comb begin
        merged.row = i_row;
        for (int c = 0; c < kcd_pkg::SCAN_COLS; c++) begin
            merged.states[c]     = lane_res[c].state;
            merged.click_mask[c] = lane_res[c].click;
            merged.hold_mask[c]  = lane_res[c].hold;
        end
    end

    // result register with skid slot so a new request can enter while a
    // result is stalled downstream
    kcd_skid u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_data  (merged),
        .o_room  (out_room),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (out_data)
    );

    assign o_row_out    = out_data.row;
    assign o_key0_state = out_data.states[0];
    assign o_key1_state = out_data.states[1];
    assign o_key2_state = out_data.states[2];
    assign o_key3_state = out_data.states[3];
    assign o_click_mask = out_data.click_mask;
    assign o_hold_mask  = out_data.hold_mask;

endmodule

>>> sv/kcd_lane.sv
// One key lane: next-state logic plus click and hold flags.
module kcd_lane (
    input  kcd_pkg::t_state               i_state,
    input  logic                          i_pressed,
    input  logic [kcd_pkg::HOLD_W-1:0]    i_hold_count,
    output kcd_pkg::t_lane_res            o_res
);

    logic signed [kcd_pkg::STATE_W:0] s_ext;
    logic signed [kcd_pkg::STATE_W:0] h_ext;
    logic signed [kcd_pkg::STATE_W:0] ns_ext;
    kcd_pkg::t_state                  ns;

    assign s_ext = {i_state[kcd_pkg::STATE_W-1], i_state};
    assign h_ext = $signed({2'b00, i_hold_count});

    always_comb begin
        if (i_state == kcd_pkg::STATE_FREE) begin
            ns = i_pressed ? 8'sd1 : kcd_pkg::STATE_FREE;
        end else if (s_ext >= h_ext) begin
            // hold (or above a lowered threshold): clamp to threshold
            ns = i_pressed ? $signed({1'b0, i_hold_count}) : kcd_pkg::STATE_FREE;
        end else if (i_state == kcd_pkg::STATE_CLICK) begin
            ns = i_pressed ? 8'sd1 : kcd_pkg::STATE_FREE;
        end else if (!i_pressed) begin
            // release: a single-scan press is a bounce, a longer press reports a click
            ns = (i_state > 8'sd1) ? kcd_pkg::STATE_CLICK : kcd_pkg::STATE_FREE;
        end else begin
            ns = i_state + 8'sd1;
        end
    end

    assign ns_ext = {ns[kcd_pkg::STATE_W-1], ns};

    assign o_res.state = ns;
    assign o_res.click = (ns == kcd_pkg::STATE_CLICK);
    assign o_res.hold  = (ns > 8'sd0) && (ns_ext >= h_ext);

endmodule

>>> sv/kcd_skid.sv
// Two-entry output buffer: result register plus skid slot.
module kcd_skid (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  kcd_pkg::t_result i_data,
    output logic             o_room,
    output logic             o_valid,
    input  logic             i_ready,
    output kcd_pkg::t_result o_data
);

    logic             r_main_valid;
    logic             r_skid_valid;
    kcd_pkg::t_result r_main;
    kcd_pkg::t_result r_skid;
    logic             pop;

    assign pop     = r_main_valid && i_ready;
    assign o_room  = !r_skid_valid;
    assign o_valid = r_main_valid;
    assign o_data  = r_main;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_main_valid || pop) begin
            if (r_skid_valid) begin
                r_main_valid <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_main_valid <= i_push;
            end
        end else if (i_push) begin
            r_skid_valid <= 1'b1;
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        if (!r_main_valid || pop) begin
            r_main <= r_skid_valid ? r_skid : i_data;
        end else if (i_push) begin
            r_skid <= i_data;
        end
    end

endmodule

>>> sv/kcd_checker.sv
// Port-level checker for the keypad scan detector, bound to the top level.
module kcd_checker (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              o_valid,
    input  logic              i_ready,
    input  logic [1:0]        o_row_out,
    input  logic signed [7:0] o_key0_state,
    input  logic signed [7:0] o_key1_state,
    input  logic signed [7:0] o_key2_state,
    input  logic signed [7:0] o_key3_state,
    input  logic [3:0]        o_click_mask,
    input  logic [3:0]        o_hold_mask,
    input  logic              pready
);

    // a key cannot be clicked and held at once
    a_mask_disjoint: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_click_mask & o_hold_mask) == 4'd0))
        else $error("click and hold masks overlap");

    // click flag tracks a state of -1
    a_click_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_click_mask[0] == (o_key0_state == -8'sd1)) &&
                    (o_click_mask[1] == (o_key1_state == -8'sd1)) &&
                    (o_click_mask[2] == (o_key2_state == -8'sd1)) &&
                    (o_click_mask[3] == (o_key3_state == -8'sd1)))
        else $error("click mask disagrees with key states");

    // hold flag only on a positive count
    a_hold_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (!o_hold_mask[0] || o_key0_state > 8'sd0) &&
                    (!o_hold_mask[1] || o_key1_state > 8'sd0) &&
                    (!o_hold_mask[2] || o_key2_state > 8'sd0) &&
                    (!o_hold_mask[3] || o_key3_state > 8'sd0))
        else $error("hold flag on a non-positive state");

    // stalled result holds: row, key 0 and key 3 states and click mask stay stable
    a_out_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_row_out) &&
            $stable(o_key0_state) && $stable(o_key3_state) && $stable(o_click_mask))
        else $error("stalled result changed");

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n) pready)
        else $error("pready dropped");

endmodule

bind keypad_scan_click_hold_detect_top kcd_checker u_kcd_checker (.*);
